/* design/lwbs_pkg.sv */
// Shared constants, types and helpers for the longest bounded-sum window block.
`default_nettype none

package lwbs_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_W      = 16;

    localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    // A full window of maximal values must fit.
    localparam int SUM_W   = VALUE_W + CNT_W;
    localparam int LIMIT_W = 32;
    localparam int CMP_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int OSUM_W  = 32;
    localparam int OLEN_W  = 11;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_TRIM
    } t_state;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [VALUE_W-1:0] wdata;
        logic [PTR_W-1:0] raddr;
    } t_store_req;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(WINDOW_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/lwbs_store.sv */
// Window value memory: one write port, one registered read port with write forwarding.
`default_nettype none

module lwbs_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lwbs_pkg::t_store_req      i_req,
    output logic [lwbs_pkg::VALUE_W-1:0]   o_rdata
);
    import lwbs_pkg::*;

    logic [VALUE_W-1:0] r_mem [WINDOW_DEPTH];
    logic [VALUE_W-1:0] r_rdata;
    logic [VALUE_W-1:0] r_fwd_data;
    logic               r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata    <= r_mem[i_req.raddr];
        r_fwd_data <= i_req.wdata;
    end

    // Same-address write and read in one cycle: hand the new value on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_req.we && (i_req.waddr == i_req.raddr);
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

`default_nettype wire

/* design/longest_window_bounded_sum_top.sv */
// Top level of the longest bounded-sum window tracker.
//
// Values arrive one per transaction and are appended to a window held in a
// 1024-entry memory; values then leave from the front while the window sum
// exceeds the configured limit, and the longest window seen is recorded. The
// transaction marked last produces one result (best sum and length) and clears
// the window and best record; the limit is kept. An item is taken in the idle
// state and then held in the trim state while values are dropped from the
// front, as the memory read port yields one front value per cycle; each value
// leaves at most once. No new item is taken before the block is idle again.
// The last item of a sequence also waits while an earlier result is still held
// unaccepted in the output register. A full window forces its oldest value out
// on append within the same cycle. No clearing pass is needed after reset.
// The limit may be written only while the block is idle.
`default_nettype none

module longest_window_bounded_sum_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lwbs_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [lwbs_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_last,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [lwbs_pkg::OSUM_W-1:0]      o_best_sum,
    output logic [lwbs_pkg::OLEN_W-1:0]      o_best_length
);
    import lwbs_pkg::*;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_best_len, n_best_len;
    logic [SUM_W-1:0]   r_best_sum, n_best_sum;
    logic               r_last, n_last;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid, n_out_valid;
    logic [OSUM_W-1:0]  r_out_sum, n_out_sum;
    logic [OLEN_W-1:0]  r_out_len, n_out_len;

    t_store_req         store_req;
    logic [VALUE_W-1:0] front_value;

    logic               accept;
    logic               over_limit;
    logic               out_free;
    logic               pop;
    logic               finish;
    logic               full;
    logic               longer;
    logic [CNT_W-1:0]   upd_len;
    logic [SUM_W-1:0]   upd_sum;

    lwbs_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rdata (front_value)
    );

    assign full       = (r_count == CNT_W'(WINDOW_DEPTH));
    assign over_limit = (r_count != '0) && (CMP_W'(r_sum) > CMP_W'(r_limit));
    assign out_free   = !r_out_valid || i_out_ready;
    assign longer     = (r_count > r_best_len);
    assign upd_len    = longer ? r_count : r_best_len;
    assign upd_sum    = longer ? r_sum : r_best_sum;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (!over_limit && (!r_last || out_free)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and control
    always_comb begin
        o_in_ready = 1'b0;
        accept     = 1'b0;
        pop        = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
            end
            ST_TRIM: begin
                pop    = over_limit;
                finish = !over_limit && (!r_last || out_free);
            end
            default: ;
        endcase
    end

    // Datapath
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sum       = r_sum;
        n_best_len  = r_best_len;
        n_best_sum  = r_best_sum;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sum   = r_out_sum;
        n_out_len   = r_out_len;

        if (accept) begin
            n_tail = ptr_next(r_tail);
            n_last = i_last;
            if (full) begin
                // Oldest value is forced out as the new one goes in.
                n_head = ptr_next(r_head);
                n_sum  = r_sum - SUM_W'(front_value) + SUM_W'(i_value);
            end else begin
                n_count = r_count + CNT_W'(1);
                n_sum   = r_sum + SUM_W'(i_value);
            end
        end

        if (pop) begin
            n_head  = ptr_next(r_head);
            n_count = r_count - CNT_W'(1);
            n_sum   = r_sum - SUM_W'(front_value);
        end

        if (finish) begin
            n_best_len = upd_len;
            n_best_sum = upd_sum;
            if (r_last) begin
                n_out_valid = 1'b1;
                n_out_sum   = OSUM_W'(upd_sum);
                n_out_len   = OLEN_W'(upd_len);
                n_head      = '0;
                n_tail      = '0;
                n_count     = '0;
                n_sum       = '0;
                n_best_len  = '0;
                n_best_sum  = '0;
            end
        end
    end

    always_comb begin
        store_req.we    = accept;
        store_req.waddr = r_tail;
        store_req.wdata = i_value;
        store_req.raddr = n_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_best_len  <= '0;
            r_best_sum  <= '0;
            r_last      <= 1'b0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_best_len  <= n_best_len;
            r_best_sum  <= n_best_sum;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum <= n_out_sum;
        r_out_len <= n_out_len;
    end

    assign o_out_valid   = r_out_valid;
    assign o_best_sum    = r_out_sum;
    assign o_best_length = r_out_len;

endmodule

`default_nettype wire

/* design/lwbs_checker.sv */
// Port-level checks for the longest bounded-sum window block, bound to the top level.
`default_nettype none

module lwbs_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [lwbs_pkg::OSUM_W-1:0] o_best_sum,
    input wire logic [lwbs_pkg::OLEN_W-1:0] o_best_length
);
    import lwbs_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && o_in_ready;

    // A result held back by the sink keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_best_sum) && $stable(o_best_length))
        else $error("result changed while stalled");

    // One item in flight: no second transaction straight after the first.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // A result never appears in the cycle after an input transaction.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_best_length <= OLEN_W'(WINDOW_DEPTH)))
        else $error("best length beyond window depth");

    // An empty best window carries no sum.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_best_length == '0) |-> (o_best_sum == '0))
        else $error("non-zero sum for empty window");

endmodule

bind longest_window_bounded_sum_top lwbs_checker u_lwbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_best_sum    (o_best_sum),
    .o_best_length (o_best_length)
);

`default_nettype wire
